FILE: rtl/ssfg_pkg.sv
// ---------------------------------------------------------------------------
// ssfg_pkg: shared constants for the seven-segment frame generator
// Frame byte values and the digit-to-segment lookup.
// ---------------------------------------------------------------------------
package ssfg_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned ModeWidth  = 2;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned BcdDigits  = 5;
  localparam int unsigned BcdWidth   = 4 * BcdDigits;

  // Display modes
  localparam logic [ModeWidth-1:0] MODE_SLEEP  = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_PLAIN  = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_CHOOSE = 2'd2;
  localparam logic [ModeWidth-1:0] MODE_TMATCH = 2'd3;

  // Select and segment bytes (segments are active low)
  localparam logic [ByteWidth-1:0] SEL_START  = 8'b0000_1000;
  localparam logic [ByteWidth-1:0] SEL_FLAG   = 8'b0000_0001;
  localparam logic [ByteWidth-1:0] SEL_OFF    = 8'b0000_0000;
  localparam logic [ByteWidth-1:0] SEG_DASH   = 8'b1011_1111;
  localparam logic [ByteWidth-1:0] SEG_CHOOSE = 8'b1111_0111;
  localparam logic [ByteWidth-1:0] SEG_TMATCH = 8'b0111_1111;
  localparam logic [ByteWidth-1:0] SEG_OFF    = 8'b1111_1111;

  function automatic logic [ByteWidth-1:0] digit_pattern(input logic [3:0] digit);
    logic [ByteWidth-1:0] pat;
    unique case (digit)
      4'd0:    pat = 8'b1100_0000;
      4'd1:    pat = 8'b1100_1111;
      4'd2:    pat = 8'b1010_0100;
      4'd3:    pat = 8'b1011_0000;
      4'd4:    pat = 8'b1001_1001;
      4'd5:    pat = 8'b1001_0010;
      4'd6:    pat = 8'b1000_0010;
      4'd7:    pat = 8'b1111_1000;
      4'd8:    pat = 8'b1000_0000;
      4'd9:    pat = 8'b1001_0000;
      default: pat = SEG_OFF;
    endcase
    return pat;
  endfunction

endpackage

FILE: rtl/seven_segment_frame_generator_unit.sv
// ---------------------------------------------------------------------------
// seven_segment_frame_generator_unit: value to seven-segment frame stream
// In numeric modes the value first passes a bit-serial binary-to-BCD shift
//   loop before the first frame; sleep mode goes straight to the dash frames.
// A new request is taken only in idle, once the closing frame of the
//   previous run has been loaded into the output register.
// Frames leave one per cycle unless the output side stalls.
// Reset (rst, synchronous): FSM to idle, output register emptied.
// ---------------------------------------------------------------------------
module seven_segment_frame_generator_unit (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // frame side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] digit_select, [15:8] segments
  output logic        m_tlast    // last: closing all-off frame
);

  localparam int unsigned VW = ssfg_pkg::ValueWidth;
  localparam int unsigned BW = ssfg_pkg::BcdWidth;

  // FSM codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_FLAG  = 3'd2;
  localparam logic [2:0] S_DIGIT = 3'd3;
  localparam logic [2:0] S_DASH  = 3'd4;
  localparam logic [2:0] S_OFF   = 3'd5;

  logic [2:0]    state;
  logic [VW-1:0] bin;        // value, shifted out MSB first
  logic [BW-1:0] bcd;        // BCD digits, LS digit in [3:0]
  logic [BW-1:0] bcd_next;   // double-dabble step
  logic [3:0]    cnt;        // shift count, 16 steps
  logic          tmatch;     // flag kind: 1 temperature match, 0 choose
  logic          flag_mode;  // choose-indicator request
  logic [7:0]    sel;        // running digit-select byte
  logic          load;       // output register free this cycle

  assign s_tready = (state == S_IDLE);
  assign load     = !m_tvalid || m_tready;

  // One double-dabble step: add 3 to every digit of 5 or more, then shift in
  // the next value bit. Carries out of the top digit cannot happen for 16 bits.
  always_comb begin
    logic [BW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < ssfg_pkg::BcdDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[BW-2:0], bin[VW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (s_tvalid) begin
            bin    <= s_tdata;
            bcd    <= '0;
            cnt    <= '0;
            tmatch <= (s_tuser == ssfg_pkg::MODE_TMATCH);
            sel    <= ssfg_pkg::SEL_START;
            if (s_tuser == ssfg_pkg::MODE_SLEEP) begin
              state <= S_DASH;
            end else if (s_tuser == ssfg_pkg::MODE_PLAIN) begin
              state <= S_CONV;
            end else begin
              state <= S_CONV;
            end
          end
        end
        S_CONV: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          bcd <= bcd_next;
          bin <= {bin[VW-2:0], 1'b0};
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            // indicator modes carry a flag frame ahead of the digits
            state <= (tmatch || flag_mode) ? S_FLAG : S_DIGIT;
          end
        end
        S_FLAG: begin
          if (load) begin
            m_tvalid        <= 1'b1;
            m_tdata[7:0]    <= ssfg_pkg::SEL_FLAG;
            m_tdata[15:8]   <= tmatch ? ssfg_pkg::SEG_TMATCH : ssfg_pkg::SEG_CHOOSE;
            m_tlast         <= 1'b0;
            state           <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (load) begin
            m_tvalid      <= 1'b1;
            m_tdata[7:0]  <= sel;
            m_tdata[15:8] <= ssfg_pkg::digit_pattern(bcd[3:0]);
            m_tlast       <= 1'b0;
            sel           <= {1'b0, sel[7:1]};
            bcd           <= {4'd0, bcd[BW-1:4]};
            // leading zeros suppressed; the first digit always goes out
            if (bcd[BW-1:4] == '0) begin
              state <= S_OFF;
            end
          end
        end
        S_DASH: begin
          if (load) begin
            m_tvalid      <= 1'b1;
            m_tdata[7:0]  <= sel;
            m_tdata[15:8] <= ssfg_pkg::SEG_DASH;
            m_tlast       <= 1'b0;
            sel           <= {1'b0, sel[7:1]};
            if (sel == ssfg_pkg::SEL_FLAG) begin
              state <= S_OFF;
            end
          end
        end
        S_OFF: begin
          if (load) begin
            m_tvalid      <= 1'b1;
            m_tdata[7:0]  <= ssfg_pkg::SEL_OFF;
            m_tdata[15:8] <= ssfg_pkg::SEG_OFF;
            m_tlast       <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          state <= S_IDLE;
        end
      endcase
    end
  end

  // choose-indicator requests: mode code kept as a one-bit note
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      flag_mode <= (s_tuser == ssfg_pkg::MODE_CHOOSE);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // closing frame always carries the all-off bytes
  a_last_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == {ssfg_pkg::SEG_OFF, ssfg_pkg::SEL_OFF})
    else $error("last frame is not the all-off frame");

  // a taken request drops ready, blocking further requests while its run goes on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // dash walk never runs the select byte out
  a_dash_sel: assert property (@(posedge clk) disable iff (rst)
    state == S_DASH |-> sel != ssfg_pkg::SEL_OFF)
    else $error("dash frame with empty select");

  // a non-final frame with no select line is a fifth digit, never blank
  a_fifth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast && m_tdata[7:0] == ssfg_pkg::SEL_OFF
      |-> m_tdata[15:8] != ssfg_pkg::SEG_OFF)
    else $error("blank fifth digit frame");

endmodule
